// ===== rtl/zmm_pkg.sv =====
// Shared types, widths and codes of the zonal average / minimum / maximum aggregator.
package zmm_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int COUNT_WIDTH = 24;
	localparam int ZONE_WIDTH = 16;
	localparam int TOTAL_WIDTH = 32;
	localparam int SUM_WIDTH = 64;
	localparam int THR_WIDTH = 17;
	localparam int THR_FRAC = 16;
	localparam int MODE_WIDTH = 2;
	localparam int CFG_INDEX_WIDTH = 2;
	localparam int CFG_DATA_WIDTH = 32;
	localparam int PROD_WIDTH = VALUE_WIDTH + COUNT_WIDTH;
	localparam int THR_PROD_WIDTH = THR_WIDTH + TOTAL_WIDTH + 1;
	localparam int DIV_CNT_WIDTH = $clog2(SUM_WIDTH);

	localparam logic [MODE_WIDTH-1:0] MODE_AVG = 2'd0;
	localparam logic [MODE_WIDTH-1:0] MODE_MIN = 2'd1;
	localparam logic [MODE_WIDTH-1:0] MODE_MAX = 2'd2;

	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_AGG_MODE = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_THRESHOLD = 2'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MISSING = 2'd2;

	// -9999.0 in Q16.16
	localparam logic [VALUE_WIDTH-1:0] MISSING_RESET = 32'hD8F1_0000;

	typedef struct packed {
		logic [ZONE_WIDTH-1:0]         zone_index;
		logic                          first_of_zone;
		logic                          last_of_zone;
		logic [COUNT_WIDTH-1:0]        prior_null_count;
		logic [COUNT_WIDTH-1:0]        point_count;
		logic signed [VALUE_WIDTH-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic [ZONE_WIDTH-1:0]         zone_out;
		logic                          zone_valid;
		logic signed [VALUE_WIDTH-1:0] aggregate_value;
		logic [TOTAL_WIDTH-1:0]        valid_points;
		logic [TOTAL_WIDTH-1:0]        null_points;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic acc;
		logic thr;
		logic cmp;
		logic step;
		logic rnd;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic go_div;
		logic out_free;
	} sts_t;

endpackage

// ===== rtl/zonal_avg_min_max_aggregator_top.sv =====
// Top level of the zonal average / minimum / maximum aggregator.
// An entry without the last flag passes the multiply and accumulate states before the next
// entry is accepted. A last entry then passes the threshold, compare and output states; in
// average mode with a valid zone, the 64-step one-bit-per-cycle divider and rounding come between.
// The result register frees the input side: the next zone's entries are taken while
// a result beat still waits. Reset (arst_n low) clears counts, sum and state and sets config to its defaults.
module zonal_avg_min_max_aggregator_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  zmm_pkg::in_item_t                     in_data,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output zmm_pkg::out_item_t                    out_data,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [zmm_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
	input  logic [zmm_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);

	zmm_pkg::cmd_t cmd;
	zmm_pkg::sts_t sts;

	// Config writes go straight into the config registers; always ready for a config beat.
	assign cfg_ready = 1'b1;

	// Sequencer: one entry at a time, hold the input until the item register is free.
	zmm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: accumulate per entry, test the zone and, in average mode, divide at its last entry,
	// then drop the result into the output register and clear the accumulators.
	zmm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.cfg_we    (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

// ===== rtl/zmm_div.sv =====
// Restoring divider, one quotient bit per step.
module zmm_div (
	input  logic                              clk,
	input  logic                              load,
	input  logic                              step,
	input  logic [zmm_pkg::SUM_WIDTH-1:0]     dividend,
	input  logic [zmm_pkg::TOTAL_WIDTH-1:0]   divisor,
	output logic [zmm_pkg::SUM_WIDTH-1:0]     quo,
	output logic [zmm_pkg::TOTAL_WIDTH-1:0]   rem
);

	logic [zmm_pkg::SUM_WIDTH-1:0]   quo_q;
	logic [zmm_pkg::TOTAL_WIDTH-1:0] rem_q;
	logic [zmm_pkg::TOTAL_WIDTH-1:0] dsr_q;
	logic [zmm_pkg::TOTAL_WIDTH:0]   shifted;
	logic [zmm_pkg::TOTAL_WIDTH:0]   diff;
	logic                            ge;

	assign shifted = {rem_q, quo_q[zmm_pkg::SUM_WIDTH-1]};
	assign ge      = shifted >= {1'b0, dsr_q};
	assign diff    = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk) begin
		if (load) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (step) begin
			rem_q <= ge ? diff[zmm_pkg::TOTAL_WIDTH-1:0] : shifted[zmm_pkg::TOTAL_WIDTH-1:0];
			quo_q <= {quo_q[zmm_pkg::SUM_WIDTH-2:0], ge};
		end
	end

	assign quo = quo_q;
	assign rem = rem_q;

endmodule

// ===== rtl/zmm_dp.sv =====
// Datapath: item register, accumulators, threshold test, averaging and result register.
module zmm_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  zmm_pkg::cmd_t                         cmd,
	output zmm_pkg::sts_t                         sts,
	input  zmm_pkg::in_item_t                     in_data,
	input  logic                                  cfg_we,
	input  logic [zmm_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
	input  logic [zmm_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
	input  logic                                  out_ready,
	output logic                                  out_valid,
	output zmm_pkg::out_item_t                    out_data
);

	localparam int VW = zmm_pkg::VALUE_WIDTH;
	localparam int SW = zmm_pkg::SUM_WIDTH;
	localparam int TW = zmm_pkg::TOTAL_WIDTH;
	localparam logic [SW-1:0] POS_LIM = {{(SW-VW+1){1'b0}}, {(VW-1){1'b1}}};
	localparam logic [SW-1:0] NEG_LIM = POS_LIM + 1'b1;
	localparam logic signed [SW-1:0] SUM_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] SUM_MIN = {1'b1, {(SW-1){1'b0}}};

	function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a,
			input logic [zmm_pkg::COUNT_WIDTH-1:0] b);
		logic [TW:0] s;
		s = {1'b0, a} + (TW+1)'(b);
		return s[TW] ? '1 : s[TW-1:0];
	endfunction

	// configuration
	logic [zmm_pkg::MODE_WIDTH-1:0] mode_q;
	logic [zmm_pkg::THR_WIDTH-1:0]  thr_q;
	logic [VW-1:0]                  miss_q;

	// item and multiply stage
	zmm_pkg::in_item_t           item_q;
	logic [zmm_pkg::PROD_WIDTH-1:0] prod_s1;
	logic                        neg_s1;
	logic                        nul_s1;
	logic                        live_s1;

	// accumulators
	logic signed [SW-1:0] sum_q;
	logic signed [VW-1:0] ext_q;
	logic                 seeded_q;
	logic [TW-1:0]        vtot_q;
	logic [TW-1:0]        ntot_q;

	// end of zone
	logic [zmm_pkg::THR_PROD_WIDTH-1:0] thrprod_q;
	logic                               zvalid_q;
	logic                               sneg_q;
	logic [VW-1:0]                      avg_q;
	logic                               out_valid_q;
	zmm_pkg::out_item_t                 out_q;

	logic [VW-1:0]                      val_u;
	logic [VW-1:0]                      mag_v;
	logic [SW-1:0]                      term;
	logic signed [SW:0]                 sum_ext;
	logic [TW:0]                        total;
	logic                               zone_ok;
	logic [SW-1:0]                      sum_mag;
	logic [SW-1:0]                      quo;
	logic [TW-1:0]                      rem;
	logic                               round_up;
	logic [SW-1:0]                      q_rnd;
	logic [SW-1:0]                      q_lim;
	logic [SW-1:0]                      q_clamp;
	logic [SW-1:0]                      q_signed;
	logic signed [VW-1:0]               agg_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= zmm_pkg::MODE_AVG;
			thr_q  <= '0;
			miss_q <= zmm_pkg::MISSING_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				zmm_pkg::CFG_AGG_MODE:  mode_q <= cfg_data[zmm_pkg::MODE_WIDTH-1:0];
				zmm_pkg::CFG_THRESHOLD: thr_q  <= cfg_data[zmm_pkg::THR_WIDTH-1:0];
				zmm_pkg::CFG_MISSING:   miss_q <= cfg_data[VW-1:0];
				default: ;
			endcase
		end
	end

	assign val_u = item_q.value;
	assign mag_v = val_u[VW-1] ? (~val_u + 1'b1) : val_u;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_data;
		end
		if (cmd.mul) begin
			prod_s1 <= zmm_pkg::PROD_WIDTH'(mag_v) * zmm_pkg::PROD_WIDTH'(item_q.point_count);
			neg_s1  <= val_u[VW-1];
			nul_s1  <= val_u == miss_q;
			live_s1 <= item_q.point_count != '0;
		end
	end

	assign term    = neg_s1 ? (~SW'(prod_s1) + 1'b1) : SW'(prod_s1);
	assign sum_ext = {sum_q[SW-1], sum_q} + {term[SW-1], term};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			ext_q    <= '0;
			seeded_q <= 1'b0;
			vtot_q   <= '0;
			ntot_q   <= '0;
		end else if (cmd.emit) begin
			sum_q    <= '0;
			ext_q    <= '0;
			seeded_q <= 1'b0;
			vtot_q   <= '0;
			ntot_q   <= '0;
		end else if (cmd.mul && item_q.first_of_zone) begin
			sum_q    <= '0;
			ext_q    <= '0;
			seeded_q <= 1'b0;
			vtot_q   <= '0;
			ntot_q   <= TW'(item_q.prior_null_count);
		end else if (cmd.acc && live_s1) begin
			if (nul_s1) begin
				ntot_q <= sat_add(ntot_q, item_q.point_count);
			end else begin
				vtot_q <= sat_add(vtot_q, item_q.point_count);
				if (sum_ext[SW] != sum_ext[SW-1]) begin
					sum_q <= sum_ext[SW] ? SUM_MIN : SUM_MAX;
				end else begin
					sum_q <= sum_ext[SW-1:0];
				end
				// first valid value seeds the extreme, whatever the mode
				if (!seeded_q) begin
					ext_q    <= item_q.value;
					seeded_q <= 1'b1;
				end else if (mode_q == zmm_pkg::MODE_MIN && item_q.value < ext_q) begin
					ext_q <= item_q.value;
				end else if (mode_q == zmm_pkg::MODE_MAX && item_q.value > ext_q) begin
					ext_q <= item_q.value;
				end
			end
		end
	end

	assign total   = {1'b0, vtot_q} + {1'b0, ntot_q};
	assign zone_ok = (vtot_q != '0) &&
		(zmm_pkg::THR_PROD_WIDTH'({vtot_q, {zmm_pkg::THR_FRAC{1'b0}}}) >= thrprod_q);
	assign sum_mag = sum_q[SW-1] ? (~sum_q + 1'b1) : sum_q;

	zmm_div u_div (
		.clk      (clk),
		.load     (cmd.cmp),
		.step     (cmd.step),
		.dividend (sum_mag),
		.divisor  (vtot_q),
		.quo      (quo),
		.rem      (rem)
	);

	// round half away from zero on the magnitude, then clamp to the value range
	assign round_up = {rem, 1'b0} >= {1'b0, vtot_q};
	assign q_rnd    = quo + SW'(round_up);
	assign q_lim    = sneg_q ? NEG_LIM : POS_LIM;
	assign q_clamp  = (q_rnd > q_lim) ? q_lim : q_rnd;
	assign q_signed = sneg_q ? (~q_clamp + 1'b1) : q_clamp;

	always_ff @(posedge clk) begin
		if (cmd.thr) begin
			thrprod_q <= zmm_pkg::THR_PROD_WIDTH'(thr_q) * zmm_pkg::THR_PROD_WIDTH'(total);
		end
		if (cmd.cmp) begin
			zvalid_q <= zone_ok;
			sneg_q   <= sum_q[SW-1];
		end
		if (cmd.rnd) begin
			avg_q <= q_signed[VW-1:0];
		end
	end

	always_comb begin
		agg_sel = miss_q;
		if (zvalid_q) begin
			priority if (mode_q == zmm_pkg::MODE_AVG) begin
				agg_sel = avg_q;
			end else if (mode_q == zmm_pkg::MODE_MIN || mode_q == zmm_pkg::MODE_MAX) begin
				agg_sel = ext_q;
			end else begin
				agg_sel = miss_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.zone_out        <= item_q.zone_index;
			out_q.zone_valid      <= zvalid_q;
			out_q.aggregate_value <= agg_sel;
			out_q.valid_points    <= vtot_q;
			out_q.null_points     <= ntot_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_data     = out_q;
	assign sts.last     = item_q.last_of_zone;
	assign sts.go_div   = zone_ok && (mode_q == zmm_pkg::MODE_AVG);
	assign sts.out_free = !out_valid_q || out_ready;

endmodule

// ===== rtl/zmm_ctrl.sv =====
// Controller: sequences multiply, accumulate, threshold, compare, divide, round and result steps.
module zmm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  zmm_pkg::sts_t sts,
	output zmm_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_ACC,
		S_THR,
		S_CMP,
		S_DIV,
		S_RND,
		S_OUT
	} state_t;

	localparam logic [zmm_pkg::DIV_CNT_WIDTH-1:0] DIV_LAST =
		zmm_pkg::DIV_CNT_WIDTH'(zmm_pkg::SUM_WIDTH - 1);

	state_t                             state_q;
	logic [zmm_pkg::DIV_CNT_WIDTH-1:0]  div_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			div_cnt_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_MUL;
				S_MUL:  state_q <= S_ACC;
				S_ACC:  state_q <= sts.last ? S_THR : S_IDLE;
				S_THR:  state_q <= S_CMP;
				S_CMP: begin
					div_cnt_q <= '0;
					state_q   <= sts.go_div ? S_DIV : S_OUT;
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DIV_LAST) state_q <= S_RND;
				end
				S_RND:  state_q <= S_OUT;
				S_OUT:  if (sts.out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready = state_q == S_IDLE;
	assign cmd.load = (state_q == S_IDLE) && in_valid;
	assign cmd.mul  = state_q == S_MUL;
	assign cmd.acc  = state_q == S_ACC;
	assign cmd.thr  = state_q == S_THR;
	assign cmd.cmp  = state_q == S_CMP;
	assign cmd.step = state_q == S_DIV;
	assign cmd.rnd  = state_q == S_RND;
	assign cmd.emit = (state_q == S_OUT) && sts.out_free;

endmodule

// ===== rtl/zmm_checker.sv =====
// Port-level checker for the aggregator, bound to the top level.
module zmm_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_valid,
	input logic                                  in_ready,
	input zmm_pkg::in_item_t                     in_data,
	input logic                                  out_valid,
	input logic                                  out_ready,
	input zmm_pkg::out_item_t                    out_data,
	input logic                                  cfg_valid,
	input logic                                  cfg_ready,
	input logic [zmm_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
	input logic [zmm_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);

	// A stalled result beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// Each entry keeps the input closed while it passes the multiply and accumulate states.
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
		else $error("input reopened too early after an entry");

	// A new result leaves the sequencer idle and ready for the next zone.
	a_rise_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result appeared while an entry was in work");

	// A valid zone has valid points.
	a_valid_pts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.zone_valid |-> out_data.valid_points != '0)
		else $error("zone flagged valid with no valid points");

endmodule

bind zonal_avg_min_max_aggregator_top zmm_checker u_zmm_checker (.*);
